// ----- rtl/ksm_pkg.sv -----
// ---------------------------------------------------------------------------
// ksm_pkg
// Shared types and constants of the key sequence matcher.
// ---------------------------------------------------------------------------
package ksm_pkg;
    localparam int NUM_SEQ  = 16;
    localparam int MAX_ELEM = 16;
    localparam int MAX_CAP  = 9;
    localparam int KEY_W    = 8;
    localparam int SEQ_W    = 4;
    localparam int ELEM_W   = 4;
    localparam int LEN_W    = 5;
    localparam int CNT_W    = 4;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_KEY   = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [0:0] REG_PLAYER = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_SET,
        ST_RD,
        ST_EVAL,
        ST_CAPRD,
        ST_EMIT,
        ST_NOHIT
    } t_state;
endpackage

// ----- rtl/key_sequence_matcher.sv -----
// ---------------------------------------------------------------------------
// key_sequence_matcher
// Key sequence detector with captured-key arguments, held in memories.
// ---------------------------------------------------------------------------
// Loads, length writes and clears take one beat; a clear-all sweeps the
// sixteen sequence rows. A key-down beat walks the active sequences in
// index order, each with a memory read, then an evaluate and write back,
// and each emitted result takes a capture read, then the output register.
// The pattern and capture memories each have one read port. One item is
// worked on at a time.
// After reset, a clearing pass over the sixteen rows of the sequence row
// memory runs before the first beat is taken. Output beats sit in a
// register, so a stalled output only holds the block, never corrupts it.
module key_sequence_matcher
    import ksm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[1:0], seq_index[5:2], elem_position[9:6], elem_is_capture[10],
    // elem_value[18:11], seq_length[23:19], seq_capture_count[27:24],
    // key_code[35:28], zero pad [39:36]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // completed[0], eaten[1], done_sequence[5:2], player_out[9:6],
    // has_arg[10], arg_index[14:11], arg_value[22:15], zero pad [23]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    // Row memory per sequence: {length, count, position}.
    localparam int ROW_W = LEN_W + CNT_W + ELEM_W;

    logic [ROW_W-1:0] row_mem [NUM_SEQ];
    logic [8:0]       pat_mem [NUM_SEQ*MAX_ELEM];
    logic [KEY_W-1:0] cap_mem [NUM_SEQ*MAX_CAP];
    // Each capture slot's key is only valid once the slot was written since
    // its sequence was last set or cleared; the stamp bit per slot gives zero reads.
    logic [NUM_SEQ*MAX_CAP-1:0] r_capv;

    t_state r_state, n_state;
    logic [3:0] r_player;
    logic [SEQ_W-1:0] r_seq, r_sweep;
    logic [SEQ_W-1:0] r_sq;
    logic [LEN_W-1:0] r_len;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_key;
    logic        r_eat;
    logic [ROW_W-1:0] r_row;
    logic [8:0]  r_el;
    logic [KEY_W-1:0] r_capd;
    logic        r_capok;
    logic [CNT_W-1:0] r_j;
    logic        r_ov;
    logic [23:0] r_od;
    logic        r_ol;

    logic [LEN_W-1:0] row_len;
    logic [CNT_W-1:0] row_cnt;
    logic [ELEM_W-1:0] row_pos, pos0;
    logic [LEN_W-1:0] npos;
    logic hit, adv;
    logic [7:0] cap_base;
    logic out_free;

    assign pready = 1'b1;
    assign prdata = {28'd0, r_player};
    assign out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_od;
    assign m_axis_tlast = r_ol;

    assign row_len = r_row[ROW_W-1 -: LEN_W];
    assign row_cnt = r_row[ELEM_W +: CNT_W];
    assign row_pos = r_row[ELEM_W-1:0];
    assign pos0 = ({1'b0, row_pos} >= row_len) ? '0 : row_pos;
    assign adv = r_el[8] || (r_el[7:0] == r_key);
    assign npos = adv ? LEN_W'({1'b0, pos0} + 5'd1) : '0;
    assign hit = adv && (npos >= row_len);
    assign cap_base = 8'(r_seq * MAX_CAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player <= '0;
        end else if (psel && penable && pwrite && pready && paddr == REG_PLAYER) begin
            r_player <= pwdata[3:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tdata[1:0])
                        REQ_LOAD:  n_state = ST_IDLE;
                        REQ_SET:   n_state = ST_SET;
                        REQ_KEY:   n_state = ST_RD;
                        REQ_CLEAR: n_state = ST_CLR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLR:  if (r_sweep == SEQ_W'(NUM_SEQ-1)) n_state = ST_IDLE;
            ST_SET:  n_state = ST_IDLE;
            ST_RD:   n_state = ST_EVAL;
            ST_EVAL: begin
                if (row_len == '0) begin
                    n_state = (r_seq == SEQ_W'(NUM_SEQ-1)) ? ST_NOHIT : ST_RD;
                end else if (hit) begin
                    n_state = ST_CAPRD;
                end else begin
                    n_state = (r_seq == SEQ_W'(NUM_SEQ-1)) ? ST_NOHIT : ST_RD;
                end
            end
            ST_CAPRD: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (row_cnt == '0 || r_j == row_cnt - 1'b1) n_state = ST_IDLE;
                    else n_state = ST_CAPRD;
                end
            end
            ST_NOHIT: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory side: reads are registered and land in the next cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD) begin
            r_row <= row_mem[r_seq];
            r_el  <= pat_mem[{r_seq, row_mem[r_seq][ELEM_W-1:0] >= ELEM_W'(0) &&
                     ({1'b0, row_mem[r_seq][ELEM_W-1:0]} >= row_mem[r_seq][ROW_W-1 -: LEN_W])
                     ? ELEM_W'(0) : row_mem[r_seq][ELEM_W-1:0]}];
        end
        if (r_state == ST_CAPRD) begin
            r_capd  <= cap_mem[cap_base + 8'(r_j)];
            r_capok <= r_capv[cap_base + 8'(r_j)];
        end
        if (r_state == ST_IDLE && s_axis_tvalid && s_axis_tdata[1:0] == REQ_LOAD) begin
            // Stored element: capture flag on top, key or slot number below.
            pat_mem[{s_axis_tdata[5:2], s_axis_tdata[9:6]}] <=
                {s_axis_tdata[10], s_axis_tdata[18:11]};
        end
        if (r_state == ST_CLR) row_mem[r_sweep] <= '0;
        else if (r_state == ST_SET) row_mem[r_sq] <= {r_len, r_cnt, ELEM_W'(0)};
        else if (r_state == ST_EVAL && row_len != '0)
            row_mem[r_seq] <= {row_len, row_cnt, hit ? ELEM_W'(0) : npos[ELEM_W-1:0]};
        if (r_state == ST_EVAL && row_len != '0 && r_el[8] && r_el[7:0] < 8'(MAX_CAP))
            cap_mem[cap_base + r_el[7:0]] <= r_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_sweep <= '0;
            r_ov    <= 1'b0;
            r_capv  <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_EMIT || r_state == ST_NOHIT) && out_free) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_sweep <= '0;
                    r_seq   <= '0;
                    r_eat   <= 1'b0;
                    r_j     <= '0;
                    if (s_axis_tvalid) begin
                        r_sq  <= s_axis_tdata[5:2];
                        r_len <= (s_axis_tdata[23:19] > LEN_W'(MAX_ELEM))
                                 ? LEN_W'(MAX_ELEM) : s_axis_tdata[23:19];
                        r_cnt <= (s_axis_tdata[27:24] > CNT_W'(MAX_CAP))
                                 ? CNT_W'(MAX_CAP) : s_axis_tdata[27:24];
                        r_key <= s_axis_tdata[35:28];
                        if (s_axis_tdata[1:0] == REQ_CLEAR) r_capv <= '0;
                    end
                end
                ST_CLR: r_sweep <= r_sweep + 1'b1;
                ST_SET: begin
                    // Drop the valid marks of all capture slots of this sequence.
                    r_capv <= r_capv & ~({{(NUM_SEQ*MAX_CAP-MAX_CAP){1'b0}},
                                          {MAX_CAP{1'b1}}} << (r_sq * MAX_CAP));
                end
                ST_EVAL: begin
                    if (row_len != '0 && r_el[8]) begin
                        r_eat <= 1'b1;
                        if (r_el[7:0] < 8'(MAX_CAP)) r_capv[cap_base + r_el[7:0]] <= 1'b1;
                    end else if (row_len != '0 && adv) r_eat <= 1'b0;
                    if (!(row_len != '0 && hit)) r_seq <= r_seq + 1'b1;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_od <= {1'b0, (row_cnt != '0 && r_capok) ? r_capd : 8'd0,
                                 (row_cnt != '0) ? r_j : 4'd0, row_cnt != '0,
                                 r_player, r_seq, 1'b1, 1'b1};
                        r_ol <= (row_cnt == '0 || r_j == row_cnt - 1'b1);
                        r_j  <= r_j + 1'b1;
                    end
                end
                ST_NOHIT: begin
                    if (out_free) begin
                        r_od <= {22'd0, r_eat, 1'b0};
                        r_ol <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov) else $error("result dropped");
    a_idle_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT && out_free |=> r_ov) else $error("emit lost");
`endif
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key sequence matcher: a predictor tracks the
// pattern memories and the walk, and a scoreboard compares output beats.
// ---------------------------------------------------------------------------

// One predicted or observed output beat.
typedef struct packed {
    logic       completed;
    logic       eaten;
    logic [3:0] seq;
    logic [3:0] player;
    logic       has_arg;
    logic [3:0] arg_idx;
    logic [7:0] arg_val;
    logic       last;
} t_match_beat;

class match_scoreboard;
    t_match_beat pending[$];
    int          mismatches;

    // Sequence tables as the block should hold them.
    logic [8:0] pattern_mem[16][16];
    logic [4:0] length_tab[16];
    logic [3:0] count_tab[16];
    logic [3:0] position_tab[16];
    logic [7:0] capture_tab[16][9];
    logic [3:0] player;

    function void clear_rows();
        for (int s = 0; s < 16; s++) begin
            length_tab[s] = '0;
            count_tab[s] = '0;
            position_tab[s] = '0;
            for (int c = 0; c < 9; c++) capture_tab[s][c] = '0;
        end
    endfunction

    function void reset_state();
        for (int s = 0; s < 16; s++)
            for (int e = 0; e < 16; e++) pattern_mem[s][e] = '0;
        clear_rows();
        player = '0;
        mismatches = 0;
        pending.delete();
    endfunction

    // Notes one accepted input beat and queues the beats it should cause.
    function void note_input(logic [39:0] d);
        logic [1:0] req;
        logic [3:0] sq, ep, cnt;
        logic [4:0] len;
        logic [7:0] val, key;
        logic       cap, eat;
        int         n, pos;
        t_match_beat b;
        req = d[1:0]; sq = d[5:2]; ep = d[9:6]; cap = d[10];
        val = d[18:11]; len = d[23:19]; cnt = d[27:24]; key = d[35:28];
        eat = 1'b0;
        case (req)
            ksm_pkg::REQ_LOAD: begin
                pattern_mem[sq][ep] = {cap, val};
            end
            ksm_pkg::REQ_SET: begin
                length_tab[sq] = (len > 16) ? 5'd16 : len;
                count_tab[sq] = (cnt > 9) ? 4'd9 : cnt;
                position_tab[sq] = '0;
                for (int c = 0; c < 9; c++) capture_tab[sq][c] = '0;
            end
            ksm_pkg::REQ_CLEAR: begin
                clear_rows();
            end
            default: begin
                for (int s = 0; s < 16; s++) begin
                    n = int'(length_tab[s]);
                    if (n == 0) continue;
                    pos = int'(position_tab[s]);
                    if (pos >= n) pos = 0;
                    if (pattern_mem[s][pos][8]) begin
                        if (pattern_mem[s][pos][7:0] < 9)
                            capture_tab[s][pattern_mem[s][pos][7:0]] = key;
                        pos++;
                        eat = 1'b1;
                    end else if (pattern_mem[s][pos][7:0] == key) begin
                        pos++;
                        eat = 1'b0;
                    end else begin
                        pos = 0;
                    end
                    if (pos < n) begin
                        position_tab[s] = 4'(pos);
                        continue;
                    end
                    // Completion: emit the captured keys, then stop the walk.
                    position_tab[s] = '0;
                    if (count_tab[s] == 0) begin
                        b = '{1'b1, 1'b1, s[3:0], player, 1'b0, 4'd0, 8'd0, 1'b1};
                        pending = {pending, b};
                    end else begin
                        for (int c = 0; c < count_tab[s]; c++) begin
                            b = '{1'b1, 1'b1, s[3:0], player, 1'b1, c[3:0],
                                  capture_tab[s][c], c + 1 == count_tab[s]};
                            pending = {pending, b};
                        end
                    end
                    return;
                end
                b = '{1'b0, eat, 4'd0, 4'd0, 1'b0, 4'd0, 8'd0, 1'b1};
                pending = {pending, b};
            end
        endcase
    endfunction

    // Compares one observed beat with the oldest expectation.
    function void check_beat(t_match_beat got);
        t_match_beat want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output beat %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("beat mismatch: expected %h, got %h", want, got);
        end
    endfunction
endclass

module tb_top;
    import ksm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // req_type, seq_index, elem_position, elem_is_capture, elem_value,
    // seq_length, seq_capture_count, key_code (from bit 0 up)
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // completed, eaten, done_sequence, player_out, has_arg, arg_index,
    // arg_value (from bit 0 up)
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    match_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    // Number of input beats accepted so far.
    int sent;
    // Which element positions have been loaded, so walks never read a hole.
    bit loaded[16][16];

    key_sequence_matcher dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    // The receiver stalls at random; every accepted beat is checked here.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_beat({m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[5:2],
                              m_axis_tdata[9:6], m_axis_tdata[10],
                              m_axis_tdata[14:11], m_axis_tdata[22:15], m_axis_tlast});
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sends one beat, idling first at the current rate. The valid line stays
    // high after the beat so that beats can follow without a gap.
    task automatic send_beat(logic [39:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(d);
        sent++;
    endtask

    function automatic logic [39:0] pack_req(logic [1:0] req, logic [3:0] sq,
                                             logic [3:0] ep, logic cap, logic [7:0] val,
                                             logic [4:0] len, logic [3:0] cnt,
                                             logic [7:0] key);
        return {4'd0, key, cnt, len, val, cap, ep, sq, req};
    endfunction

    task automatic send_load(int sq, int ep, bit cap, int val);
        if (sq < 16 && ep < 16) loaded[sq][ep] = 1'b1;
        send_beat(pack_req(REQ_LOAD, 4'(sq), 4'(ep), cap, 8'(val), 5'($urandom),
                           4'($urandom), 8'($urandom)));
    endtask

    // A set is sent only where every element up to the length is loaded.
    task automatic send_set(int sq, int len, int cnt);
        int n;
        n = (len > 16) ? 16 : len;
        for (int e = 0; e < n; e++)
            if (!loaded[sq][e]) send_load(sq, e, 1'b0, $urandom);
        send_beat(pack_req(REQ_SET, 4'(sq), 4'($urandom), 1'($urandom), 8'($urandom),
                           5'(len), 4'(cnt), 8'($urandom)));
    endtask

    task automatic send_key(int key);
        send_beat(pack_req(REQ_KEY, 4'($urandom), 4'($urandom), 1'($urandom),
                           8'($urandom), 5'($urandom), 4'($urandom), 8'(key)));
    endtask

    // Loads a random pattern of length len into sq; capture slots mostly in
    // range, now and then slot numbers past the last one.
    task automatic random_pattern(int sq, int len);
        for (int e = 0; e < len; e++) begin
            if ($urandom_range(2) == 0)
                send_load(sq, e, 1'b1, ($urandom_range(9) == 0) ? $urandom : $urandom_range(8));
            else
                send_load(sq, e, 1'b0, $urandom_range(15) << 4 | $urandom_range(3));
        end
        send_set(sq, len, $urandom_range(15));
    endtask

    // Waits until the block has delivered every expected beat.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_player(int value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_PLAYER; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.player = value[3:0];
    endtask

    // Sends random requests until about the given number of beats went in.
    task automatic random_phase(int items);
        int sq;
        int stop_at;
        stop_at = sent + items;
        while (sent < stop_at) begin
            case ($urandom_range(19))
                0: begin
                    sq = $urandom_range(15);
                    random_pattern(sq, $urandom_range(1, ($urandom_range(7) == 0) ? 16 : 4));
                end
                1: send_load($urandom_range(15), $urandom_range(15), 1'($urandom), $urandom);
                2: send_beat(pack_req(REQ_CLEAR, 4'($urandom), 4'($urandom), 1'($urandom),
                                      8'($urandom), 5'($urandom), 4'($urandom),
                                      8'($urandom)));
                3: send_set($urandom_range(15), $urandom_range(31), $urandom);
                default: begin
                    // Keys biased toward the literal values the patterns use.
                    if ($urandom_range(3) == 0) send_key($urandom);
                    else send_key($urandom_range(15) << 4 | $urandom_range(3));
                end
            endcase
        end
    endtask

    initial begin
        board = new();
        board.reset_state();
        sent = 0;
        send_idle_pct = 30;
        recv_idle_pct = 87;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every request, captures out of range, saturation.
        write_player(15);
        send_key(8'h00);
        send_load(0, 0, 1'b0, 8'hff);
        send_load(0, 1, 1'b1, 8'd8);
        send_load(0, 2, 1'b1, 8'd0);
        send_load(0, 3, 1'b1, 8'd200);
        send_set(0, 4, 15);
        send_key(8'hff);
        send_key(8'ha5);
        send_key(8'h5a);
        send_key(8'h01);
        send_load(15, 15, 1'b1, 8'd1);
        send_set(15, 31, 0);
        send_load(16 - 1, 0, 1'b0, 8'h00);
        send_key(8'h00);
        send_key(8'h77);
        send_beat(pack_req(REQ_CLEAR, 4'hf, 4'hf, 1'b1, 8'hff, 5'h1f, 4'hf, 8'hff));
        send_set(3, 1, 0);
        send_key(8'h11);
        send_key($urandom);
        drain();
        write_player(0);

        random_phase(150);
        // Pause the sender until every result is in.
        drain();
        write_player(7);
        send_idle_pct = 87;
        recv_idle_pct = 30;
        random_phase(150);
        drain();
        write_player($urandom_range(15));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(150);
        drain();
        repeat (100) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
